// File: design/stp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stp_pkg: shared types and constants of the stepper pulse generator
// Function codes, register indexes, state machine states, job codes and the slope limit.
// ----------------------------------------------------------------------------
package stp_pkg;

    localparam int unsigned SLOPE_MAX = 128;

    typedef enum logic [1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_HALT  = 2'd2,
        FUNC_NONE  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        REG_RATE  = 2'd0,
        REG_FMIN  = 2'd1,
        REG_LIMIT = 2'd2,
        REG_GEAR  = 2'd3
    } t_reg;

    typedef enum logic [3:0] {
        ST_IDLE,     // waiting for an input beat
        ST_MUL,      // shift-add multiply, one bit a cycle
        ST_DIV,      // restoring divide, one bit a cycle
        ST_OUT       // result beat waits for the receiver
    } t_state;

    // what a running job does once its arithmetic is done
    typedef enum logic [2:0] {
        JOB_START_T,   // T computed, compute L next
        JOB_START_L,   // L computed, then peak interval
        JOB_START_PK,  // peak interval done, then start interval
        JOB_START_MN,  // start interval done
        JOB_RAMP_F,    // ramp numerator product done, divide by L
        JOB_RAMP_Q,    // ramp frequency known, divide rate by it
        JOB_RAMP_I     // interval quotient done
    } t_job;

endpackage

// File: design/stepper_trapezoid_pulse_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_pulse_generator
// Trapezoidal step pulse generator with bit-serial multiply and divide.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall with fields func, direction, step_size,
// step_count, peak_frequency, slope_q8. One result beat per input beat on
// o_valid / i_stall.
// A tick that needs no ramp arithmetic, a halt, a refused start or an idle item
// gives its result beat in the cycle after acceptance. A start runs two 8-step
// multiplies for T and L with a setup step each, then two 64-step divides.
// A toggling tick whose next interval lies on a ramp runs a 16-step multiply,
// a setup step and two 64-step divides; the second divide is skipped when the
// ramp frequency is not above the floor.
// All arithmetic runs on the one shared shift-add/restoring-divide datapath that
// handles one bit per cycle.
// The block takes one item at a time; o_stall is high from acceptance until
// the result beat leaves, and the next beat is taken only once the block is
// back in idle. While i_stall is high the result is held.
// Reset (synchronous, active low) clears the control state and outputs and loads
// the register defaults; the arithmetic registers are not reset.
// ----------------------------------------------------------------------------
module stepper_trapezoid_pulse_generator
    import stp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic        i_direction,
    input  logic [2:0]  i_step_size,
    input  logic [15:0] i_step_count,
    input  logic [15:0] i_peak_frequency,
    input  logic [7:0]  i_slope_q8,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_step_level,
    output logic        o_direction_level,
    output logic        o_driver_enabled,
    output logic        o_busy_res,
    output logic        o_move_done,
    output logic        o_rejected,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    // configuration
    logic [31:0] r_rate;
    logic [15:0] r_fmin, r_limit;
    logic [7:0]  r_gear;

    // move state
    logic [31:0] r_n, r_tt, r_len;
    logic [15:0] r_intv, r_tick, r_pkint, r_peak;
    logic        r_step, r_dir, r_en, r_busy, r_done, r_rej;
    logic [15:0] r_start_peak;

    t_state r_st, n_st;
    t_job   r_job, n_job;

    // serial arithmetic: acc = a*b (64 bit), or q = num/den
    logic [63:0] r_acc, n_acc;   // product / remainder
    logic [63:0] r_ma, n_ma;     // multiplicand shifted left
    logic [31:0] r_mb, n_mb;     // multiplier shifted right
    logic [63:0] r_num, n_num;   // dividend shifted left
    logic [63:0] r_den, n_den;
    logic [63:0] r_q, n_q;
    logic [6:0]  r_cnt, n_cnt;

    // other next values
    logic [31:0] n_n, n_tt, n_len;
    logic [15:0] n_intv, n_tick, n_pkint, n_peak, n_start_peak;
    logic        n_step, n_dir, n_en, n_busy, n_done, n_rej;

    logic        acc_in;
    logic [64:0] trial;
    logic [31:0] right, span, tick_c;

    assign acc_in  = i_valid && (r_st == ST_IDLE);
    assign o_stall = (r_st != ST_IDLE);
    assign o_valid = (r_st == ST_OUT);

    assign o_step_level      = r_step;
    assign o_direction_level = r_dir;
    assign o_driver_enabled  = r_en;
    assign o_busy_res        = r_busy;
    assign o_move_done       = r_done;
    assign o_rejected        = r_rej;

    assign trial  = {r_acc, r_num[63]} - {1'b0, r_den};
    assign right  = r_tt - r_len;
    assign tick_c = {16'd0, r_tick} + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate  <= 32'd1000000;
            r_fmin  <= 16'd50;
            r_limit <= 16'd1000;
            r_gear  <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (t_reg'(i_cfg_index))
                REG_RATE:  r_rate  <= i_cfg_data;
                REG_FMIN:  r_fmin  <= i_cfg_data[15:0];
                REG_LIMIT: r_limit <= i_cfg_data[15:0];
                REG_GEAR:  r_gear  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= ST_IDLE;
            r_job  <= JOB_START_T;
            r_n    <= '0;
            r_tt   <= '0;
            r_len  <= '0;
            r_intv <= '0;
            r_tick <= '0;
            r_pkint <= '0;
            r_peak <= '0;
            r_step <= 1'b0;
            r_dir  <= 1'b0;
            r_en   <= 1'b0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_rej  <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_job  <= n_job;
            r_n    <= n_n;
            r_tt   <= n_tt;
            r_len  <= n_len;
            r_intv <= n_intv;
            r_tick <= n_tick;
            r_pkint <= n_pkint;
            r_peak <= n_peak;
            r_step <= n_step;
            r_dir  <= n_dir;
            r_en   <= n_en;
            r_busy <= n_busy;
            r_done <= n_done;
            r_rej  <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_num <= n_num;
        r_den <= n_den;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_start_peak <= n_start_peak;
    end

    always_comb begin
        n_st = r_st;
        n_job = r_job;
        n_acc = r_acc;
        n_ma = r_ma;
        n_mb = r_mb;
        n_num = r_num;
        n_den = r_den;
        n_q = r_q;
        n_cnt = r_cnt;
        n_n = r_n;
        n_tt = r_tt;
        n_len = r_len;
        n_intv = r_intv;
        n_tick = r_tick;
        n_pkint = r_pkint;
        n_peak = r_peak;
        n_start_peak = r_start_peak;
        n_step = r_step;
        n_dir = r_dir;
        n_en = r_en;
        n_busy = r_busy;
        n_done = r_done;
        n_rej = r_rej;
        span = '0;

        unique case (r_st)
            ST_IDLE: begin
                if (acc_in) begin
                    n_done = 1'b0;
                    n_rej  = 1'b0;
                    n_st   = ST_OUT;
                    case (t_func'(i_func))
                        FUNC_START: begin
                            if (r_busy || ({8'd0, i_slope_q8} > 16'(SLOPE_MAX)) ||
                                (i_peak_frequency > r_limit)) begin
                                n_rej = 1'b1;
                            end else begin
                                // T = steps*gear, shifted later
                                n_ma  = {48'd0, i_step_count};
                                n_mb  = {24'd0, r_gear};
                                n_acc = '0;
                                n_cnt = 7'd8;
                                n_q   = {56'd0, i_slope_q8};
                                n_den = {61'd0, i_step_size};
                                n_start_peak = i_peak_frequency;
                                n_dir = i_direction;
                                n_job = JOB_START_T;
                                n_st  = ST_MUL;
                            end
                        end
                        FUNC_HALT: begin
                            n_step = 1'b0;
                            n_en   = 1'b0;
                            n_busy = 1'b0;
                        end
                        FUNC_TICK: begin
                            if (r_busy) begin
                                if (tick_c >= {16'd0, r_intv}) begin
                                    n_tick = '0;
                                    n_step = ~r_step;
                                    n_n    = r_n + 32'd1;
                                    if (r_n + 32'd1 >= r_tt) begin
                                        n_en   = 1'b0;
                                        n_busy = 1'b0;
                                        n_done = 1'b1;
                                    end else if ((r_n + 32'd1 <= r_len) ||
                                                 ((r_n + 32'd1 >= right) &&
                                                  (r_len != 32'd0) &&
                                                  !(r_n + 32'd1 > r_len &&
                                                    r_n + 32'd1 < right))) begin
                                        span = (r_n + 32'd1 <= r_len) ? r_n + 32'd1
                                                                      : r_tt - r_n - 32'd1;
                                        n_ma  = {32'd0, span};
                                        n_mb  = {16'd0, r_peak};
                                        n_acc = '0;
                                        n_cnt = 7'd16;
                                        n_job = JOB_RAMP_F;
                                        n_st  = ST_MUL;
                                    end else if (r_n + 32'd1 > r_len &&
                                                 r_n + 32'd1 < right) begin
                                        n_intv = r_pkint;
                                    end
                                end else begin
                                    n_tick = tick_c[15:0];
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_MUL: begin
                if (r_mb[0]) n_acc = r_acc + r_ma;
                n_ma  = {r_ma[62:0], 1'b0};
                n_mb  = {1'b0, r_mb[31:1]};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_st = ST_DIV;
                    unique case (r_job)
                        JOB_START_T: begin
                            // acc done next cycle; finish in a zero-length div step
                        end
                        default: ;
                    endcase
                end
                if (r_cnt == 7'd1) begin
                    // hand off into the division setup below on the next cycle
                    n_cnt = 7'd0;
                end
            end
            ST_DIV: begin
                if (r_cnt == 7'd0) begin
                    // setup step after a multiply
                    unique case (r_job)
                        JOB_START_T: begin
                            // T = 2*steps*gear << k, kept to 32 bits; the 64-bit value feeds the L multiply
                            n_tt  = 32'((r_acc << 1) << r_den[2:0]);
                            n_ma  = ((r_acc << 1) << r_den[2:0]);
                            n_mb  = {24'd0, r_q[7:0]};
                            n_acc = '0;
                            n_cnt = 7'd8;
                            n_job = JOB_START_L;
                            n_st  = ST_MUL;
                        end
                        JOB_START_L: begin
                            n_len = 32'(r_acc >> 8);
                            n_peak = r_start_peak;
                            n_job = JOB_START_PK;
                            n_num = {32'd0, r_rate};
                            n_den = {48'd0, r_start_peak};
                            n_acc = '0;
                            n_q   = '0;
                            n_cnt = 7'd64;
                        end
                        JOB_RAMP_F: begin
                            // f = prod / L
                            n_num = r_acc;
                            n_den = {32'd0, r_len};
                            n_acc = '0;
                            n_q   = '0;
                            n_cnt = 7'd64;
                            n_job = JOB_RAMP_Q;
                        end
                        default: n_st = ST_OUT;
                    endcase
                end else begin
                    n_acc = trial[64] ? {r_acc[62:0], r_num[63]} : trial[63:0];
                    n_q   = {r_q[62:0], ~trial[64]};
                    n_num = {r_num[62:0], 1'b0};
                    n_cnt = r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        n_cnt = 7'd0;
                        n_st  = ST_DIV;
                        unique case (r_job)
                            JOB_START_PK: begin
                                n_pkint = (r_den == 64'd0) ? 16'hFFFF :
                                          (({r_q[62:0], ~trial[64]} > 64'hFFFF) ?
                                           16'hFFFF : n_q[15:0]);
                                n_num = {32'd0, r_rate};
                                n_den = {48'd0, r_fmin};
                                n_acc = '0;
                                n_q   = '0;
                                n_cnt = 7'd64;
                                n_job = JOB_START_MN;
                            end
                            JOB_START_MN: begin
                                n_intv = (r_den == 64'd0) ? 16'hFFFF :
                                         ((n_q > 64'hFFFF) ? 16'hFFFF : n_q[15:0]);
                                n_n    = '0;
                                n_tick = '0;
                                n_step = 1'b0;
                                if (r_tt == 32'd0) begin
                                    n_done = 1'b1;
                                end else begin
                                    n_en   = 1'b1;
                                    n_busy = 1'b1;
                                end
                                n_st = ST_OUT;
                            end
                            JOB_RAMP_Q: begin
                                if (n_q > {48'd0, r_fmin}) begin
                                    n_den = n_q;
                                    n_num = {32'd0, r_rate};
                                    n_acc = '0;
                                    n_q   = '0;
                                    n_cnt = 7'd64;
                                    n_job = JOB_RAMP_I;
                                end else begin
                                    n_st = ST_OUT;
                                end
                            end
                            JOB_RAMP_I: begin
                                n_intv = (n_q > 64'hFFFF) ? 16'hFFFF : n_q[15:0];
                                n_st = ST_OUT;
                            end
                            default: n_st = ST_OUT;
                        endcase
                    end
                end
            end
            ST_OUT: begin
                if (!i_stall) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // a result beat never reports done and rejected together
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_move_done && o_rejected))
        else $error("done and rejected together");

    // the driver is on exactly while a move is busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_driver_enabled == o_busy_res))
        else $error("driver and busy differ");

    // a held result beat does not change
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_step_level) &&
                                  $stable(o_move_done) && $stable(o_rejected)))
        else $error("stalled result changed");

    // no input beat is taken while a result waits
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken during output");

endmodule
